/* hw/rtl/u8to16_pkg.sv */
package u8to16_pkg;

   // code unit and per-entry sizes
   localparam int UNIT_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int MAX_UNITS = 3;
   localparam int COUNT_W   = $clog2(MAX_UNITS + 1);
   localparam int IDX_W     = $clog2(MAX_UNITS);
   localparam int HELD_D    = 3;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // lead byte classes
   localparam logic [2:0] LEN_ASCII = 3'd0;
   localparam logic [2:0] LEN_STRAY = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // lead byte masks and patterns
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] TWO_MASK   = 8'hE0;
   localparam logic [7:0] TWO_LEAD   = 8'hC0;
   localparam logic [7:0] THREE_MASK = 8'hF0;
   localparam logic [7:0] THREE_LEAD = 8'hE0;
   localparam logic [7:0] FOUR_MASK  = 8'hF8;
   localparam logic [7:0] FOUR_LEAD  = 8'hF0;

   // code unit constants
   localparam logic [UNIT_W-1:0] UNIT_INVALID = 16'hFFFD;
   localparam logic [UNIT_W-1:0] SURR_HI_BASE = 16'hD800;
   localparam logic [UNIT_W-1:0] SURR_LO_BASE = 16'hDC00;
   localparam logic [20:0]       SUPP_BASE    = 21'h10000;

   // one queue entry: the units caused by one byte, first unit in slot 0
   typedef struct packed {
      logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
      logic [COUNT_W-1:0]               count;
      logic                             string_end;
   } entry_type;

endpackage

/* hw/rtl/u8to16_front.sv */
module u8to16_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_byte,
   input  logic                   string_end,
   input  logic                   queue_full,
   output logic                   push_valid,
   output u8to16_pkg::entry_type  push_entry
);

   logic [7:0] held_bytes_ff [u8to16_pkg::HELD_D];
   logic [1:0] held_count_ff;
   logic [1:0] held_count_in;
   logic [2:0] needed_length_ff;
   logic [2:0] needed_length_in;

   logic        accept;
   logic        hold;
   logic [2:0]  byte_len;
   logic [2:0]  x1_len;
   logic [2:0]  fill;
   logic [7:0]  x1;
   logic [20:0] code4;
   logic [20:0] supp;
   logic [15:0] surr_hi;
   logic [15:0] surr_lo;

   // lead byte class
   function automatic logic [2:0] seq_length(input logic [7:0] value);
      if ((value & u8to16_pkg::ASCII_MASK) == 8'h00) begin
         return u8to16_pkg::LEN_ASCII;
      end
      if ((value & u8to16_pkg::TWO_MASK) == u8to16_pkg::TWO_LEAD) begin
         return u8to16_pkg::LEN_TWO;
      end
      if ((value & u8to16_pkg::THREE_MASK) == u8to16_pkg::THREE_LEAD) begin
         return u8to16_pkg::LEN_THREE;
      end
      if ((value & u8to16_pkg::FOUR_MASK) == u8to16_pkg::FOUR_LEAD) begin
         return u8to16_pkg::LEN_FOUR;
      end
      return u8to16_pkg::LEN_STRAY;
   endfunction

   // a byte decoded alone with nothing after it
   function automatic logic [15:0] single_unit(input logic [7:0] value);
      if (value[7] == 1'b0) begin
         return {8'h00, value};
      end
      return u8to16_pkg::UNIT_INVALID;
   endfunction

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign byte_len = seq_length(in_byte);
   assign fill     = {1'b0, held_count_ff} + 3'd1;

   // second byte of the buffer: held byte or the new one
   assign x1     = (held_count_ff >= 2'd2) ? held_bytes_ff[1] : in_byte;
   assign x1_len = seq_length(x1);

   // four byte value and surrogate pair
   assign code4   = {held_bytes_ff[0][2:0], held_bytes_ff[1][5:0],
                     held_bytes_ff[2][5:0], in_byte[5:0]};
   assign supp    = code4 - u8to16_pkg::SUPP_BASE;
   assign surr_hi = u8to16_pkg::SURR_HI_BASE + {5'b0, supp[20:10]};
   assign surr_lo = u8to16_pkg::SURR_LO_BASE + {6'b0, supp[9:0]};

   // classify the byte and build its entry
   always_comb begin
      hold                  = 1'b0;
      push_entry            = '0;
      push_entry.string_end = string_end;
      if (held_count_ff == 2'd0) begin
         if (byte_len >= u8to16_pkg::LEN_TWO && !string_end) begin
            hold = 1'b1;
         end else begin
            push_entry.units[0] = single_unit(in_byte);
            push_entry.count    = 2'd1;
         end
      end else if (fill < needed_length_ff && !string_end) begin
         hold = 1'b1;
      end else if (fill == needed_length_ff) begin
         // complete sequence
         push_entry.count = 2'd1;
         case (needed_length_ff)
            u8to16_pkg::LEN_TWO: begin
               push_entry.units[0] = {5'b0, held_bytes_ff[0][4:0], in_byte[5:0]};
            end
            u8to16_pkg::LEN_THREE: begin
               push_entry.units[0] = {held_bytes_ff[0][3:0], held_bytes_ff[1][5:0],
                                      in_byte[5:0]};
            end
            default: begin
               if (code4[20:16] != 5'd0) begin
                  push_entry.units[0] = surr_hi;
                  push_entry.units[1] = surr_lo;
                  push_entry.count    = 2'd2;
               end else begin
                  push_entry.units[0] = code4[15:0];
               end
            end
         endcase
      end else begin
         // string ends inside a sequence: lead is invalid, rest decoded again
         push_entry.units[0] = u8to16_pkg::UNIT_INVALID;
         if (held_count_ff == 2'd1) begin
            push_entry.units[1] = single_unit(in_byte);
            push_entry.count    = 2'd2;
         end else if (x1_len == u8to16_pkg::LEN_ASCII) begin
            push_entry.units[1] = {8'h00, x1};
            push_entry.units[2] = single_unit(in_byte);
            push_entry.count    = 2'd3;
         end else if (x1_len == u8to16_pkg::LEN_TWO) begin
            push_entry.units[1] = {5'b0, x1[4:0], in_byte[5:0]};
            push_entry.count    = 2'd2;
         end else begin
            push_entry.units[1] = u8to16_pkg::UNIT_INVALID;
            push_entry.units[2] = single_unit(in_byte);
            push_entry.count    = 2'd3;
         end
      end
   end

   assign push_valid = accept && !hold;

   // sequence state next values
   always_comb begin
      held_count_in    = held_count_ff;
      needed_length_in = needed_length_ff;
      if (accept) begin
         if (hold) begin
            held_count_in = held_count_ff + 2'd1;
            if (held_count_ff == 2'd0) begin
               needed_length_in = byte_len;
            end
         end else begin
            held_count_in    = 2'd0;
            needed_length_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff    <= 2'd0;
         needed_length_ff <= 3'd0;
      end else begin
         held_count_ff    <= held_count_in;
         needed_length_ff <= needed_length_in;
      end
   end

   // held bytes of the open sequence
   always_ff @(posedge clock) begin
      if (accept && hold) begin
         held_bytes_ff[held_count_ff] <= in_byte;
      end
   end

endmodule

/* hw/rtl/u8to16_queue.sv */
module u8to16_queue #(
   parameter int DEPTH = u8to16_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  u8to16_pkg::entry_type  push_entry,
   output logic                   full,
   input  logic                   pop,
   output u8to16_pkg::entry_type  head_entry,
   output logic                   empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   u8to16_pkg::entry_type entries_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign empty      = (fill_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/u8to16_back.sv */
module u8to16_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  u8to16_pkg::entry_type  head_entry,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [15:0]            code_unit,
   output logic                   run_last,
   output logic                   string_done
);

   logic [u8to16_pkg::IDX_W-1:0] unit_idx_ff;
   logic [u8to16_pkg::IDX_W-1:0] unit_idx_in;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [15:0]                  code_unit_ff;
   logic                         run_last_ff;
   logic                         string_done_ff;
   logic                         load;
   logic                         unit_last;

   // output register takes the next unit when empty or being taken
   assign load      = !queue_empty && (!out_valid_ff || out_ready);
   assign unit_last = (unit_idx_ff == u8to16_pkg::IDX_W'(head_entry.count - 1'b1));
   assign pop       = load && unit_last;

   always_comb begin
      unit_idx_in  = unit_idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         unit_idx_in  = unit_last ? '0 : unit_idx_ff + 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         unit_idx_ff  <= unit_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         code_unit_ff   <= head_entry.units[unit_idx_ff];
         run_last_ff    <= unit_last;
         string_done_ff <= unit_last && head_entry.string_end;
      end
   end

   assign out_valid   = out_valid_ff;
   assign code_unit   = code_unit_ff;
   assign run_last    = run_last_ff;
   assign string_done = string_done_ff;

endmodule

/* hw/rtl/utf8_to_utf16_decoder_unit.sv */
// an accepted byte's first unit passes through the entry queue and then the output register
// throughput: one byte per cycle; a byte that opens or extends a sequence gives no unit
// a byte that gives 2 or 3 units keeps its entry at the queue head until its last unit
// is loaded, and the front stalls only when the entry queue between them is full
// reset (synchronous, active high) drops any open sequence, empties the queue
// and clears the output valid
module utf8_to_utf16_decoder_unit #(
   parameter int QUEUE_DEPTH = u8to16_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // string_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic        rsp_tuser,   // run_last
   output logic        rsp_tlast    // string_done
);

   logic                  queue_full;
   logic                  queue_empty;
   logic                  push_valid;
   logic                  pop;
   u8to16_pkg::entry_type push_entry;
   u8to16_pkg::entry_type head_entry;

   // byte intake and classification
   u8to16_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .string_end (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // entry queue
   u8to16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty)
   );

   // unit issue
   u8to16_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_entry  (head_entry),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .code_unit   (rsp_tdata),
      .run_last    (rsp_tuser),
      .string_done (rsp_tlast)
   );

endmodule

/* bench/utf8_to_utf16_decoder_unit_test.sv */
module utf8_to_utf16_decoder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 40000;
   localparam int LONG_STALL  = 100;

   // one byte waiting to be sent
   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } byte_item_type;

   // one code unit as the block should deliver it
   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_last;
      logic        string_done;
   } code_unit_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;    // string_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [15:0] code_unit
   logic        rsp_tuser;           // run_last
   logic        rsp_tlast;           // string_done

   byte_item_type       bytes_to_send [$];
   code_unit_entry_type units_due [$];

   // mirror of the sequence being collected
   logic [7:0]  held [3];
   int unsigned held_cnt = 0;
   logic [2:0]  need_len = u8to16_pkg::LEN_ASCII;

   int unsigned send_idle_pct = 0;
   int unsigned take_idle_pct = 0;
   int unsigned stall_left = 0;
   logic        stall_kick = 1'b0;
   logic        req_taken = 1'b0;

   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned bytes_taken = 0;
   int unsigned strings_ended = 0;
   int unsigned units_seen = 0;
   int unsigned surrogate_pairs = 0;

   utf8_to_utf16_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // classify a byte in lead position
   function automatic logic [2:0] lead_class(input logic [7:0] b);
      if ((b & u8to16_pkg::ASCII_MASK) == 8'h00) return u8to16_pkg::LEN_ASCII;
      if ((b & u8to16_pkg::TWO_MASK) == u8to16_pkg::TWO_LEAD) return u8to16_pkg::LEN_TWO;
      if ((b & u8to16_pkg::THREE_MASK) == u8to16_pkg::THREE_LEAD)
         return u8to16_pkg::LEN_THREE;
      if ((b & u8to16_pkg::FOUR_MASK) == u8to16_pkg::FOUR_LEAD)
         return u8to16_pkg::LEN_FOUR;
      return u8to16_pkg::LEN_STRAY;
   endfunction

   // predict the code units caused by one accepted byte
   task automatic transcode_byte(input logic [7:0] b, input logic fin);
      logic [7:0]          seq [4];
      logic [15:0]         units [$];
      logic [20:0]         cp;
      logic [2:0]          len;
      int unsigned         n;
      int unsigned         pos;
      int unsigned         run;
      code_unit_entry_type e;
      n = 0;
      for (int k = 0; k < held_cnt; k++) begin
         seq[n] = held[k];
         n++;
      end
      seq[n] = b;
      n++;

      // collect lead and following bytes while the string goes on
      if (held_cnt == 0) begin
         len = lead_class(b);
         if (len >= u8to16_pkg::LEN_TWO && !fin) begin
            held[0] = b;
            held_cnt = 1;
            need_len = len;
            return;
         end
      end else if (n < need_len && !fin && held_cnt < 3) begin
         held[held_cnt] = b;
         held_cnt++;
         return;
      end

      // decode everything held, restarting after a lead that cannot complete
      pos = 0;
      while (pos < n) begin
         run = n - pos;
         len = lead_class(seq[pos]);
         if (len == u8to16_pkg::LEN_ASCII) begin
            units.push_back({8'h00, seq[pos]});
            pos++;
         end else if (len == u8to16_pkg::LEN_STRAY || run < len) begin
            units.push_back(u8to16_pkg::UNIT_INVALID);
            pos++;
         end else begin
            case (len)
               u8to16_pkg::LEN_TWO: begin
                  units.push_back({5'd0, seq[pos][4:0], seq[pos+1][5:0]});
               end
               u8to16_pkg::LEN_THREE: begin
                  units.push_back({seq[pos][3:0], seq[pos+1][5:0], seq[pos+2][5:0]});
               end
               default: begin
                  cp = {seq[pos][2:0], seq[pos+1][5:0],
                        seq[pos+2][5:0], seq[pos+3][5:0]};
                  if (cp >= u8to16_pkg::SUPP_BASE) begin
                     // surrogate pair, kept to 16 bits past the unicode range
                     cp = cp - u8to16_pkg::SUPP_BASE;
                     units.push_back(u8to16_pkg::SURR_HI_BASE + 16'(cp[20:10]));
                     units.push_back(u8to16_pkg::SURR_LO_BASE + 16'(cp[9:0]));
                     surrogate_pairs++;
                  end else begin
                     units.push_back(cp[15:0]);
                  end
               end
            endcase
            pos += len;
         end
      end
      held_cnt = 0;
      need_len = u8to16_pkg::LEN_ASCII;

      foreach (units[k]) begin
         e.code_unit   = units[k];
         e.run_last    = (k == units.size() - 1);
         e.string_done = (k == units.size() - 1) && fin;
         units_due.push_back(e);
      end
   endtask

   task automatic note_mismatch(input string what, input code_unit_entry_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d, %s: expected unit %h last %b done %b,",
                  cycle_count, what, want.code_unit, want.run_last, want.string_done,
                  " got unit %h last %b done %b", rsp_tdata, rsp_tuser, rsp_tlast);
   endtask

   task automatic push_byte(input logic [7:0] b, input logic fin);
      byte_item_type it;
      it.in_byte = b;
      it.string_end = fin;
      bytes_to_send.push_back(it);
   endtask

   // extremes and special cases
   task automatic add_directed();
      push_byte(8'h00, 1'b0);                                  // zero byte
      push_byte(8'h7F, 1'b1);
      push_byte(8'hFF, 1'b0);                                  // stray bytes
      push_byte(8'h80, 1'b0);
      push_byte(8'hC3, 1'b0); push_byte(8'hA9, 1'b0);
      push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
      push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0);          // surrogate pair
      push_byte(8'h98, 1'b0); push_byte(8'h80, 1'b1);
      push_byte(8'hF0, 1'b0); push_byte(8'h8F, 1'b0);          // overlong, passed through
      push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
      push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);          // beyond unicode range
      push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
      push_byte(8'hC3, 1'b1);                                  // lead on final byte
      push_byte(8'hF0, 1'b0); push_byte(8'h80, 1'b0);          // string ends inside sequence
      push_byte(8'h41, 1'b1);
      push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
   endtask

   // mostly well-formed sequences with random content, some noise and cut strings
   task automatic add_random_bytes(input int unsigned total);
      logic [7:0]  seq [4];
      int unsigned added;
      int unsigned len;
      int unsigned cut;
      added = 0;
      while (added < total) begin
         if ($urandom_range(99) < 15) begin
            seq[0] = 8'($urandom);
            len = 1;
         end else begin
            len = $urandom_range(1, 4);
            case (len)
               1:       seq[0] = 8'($urandom_range(8'h00, 8'h7F));
               2:       seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
               3:       seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
               default: seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
            endcase
            for (int k = 1; k < len; k++)
               seq[k] = ($urandom_range(9) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(8'h80, 8'hBF));
         end
         cut = len;
         if (len > 1 && $urandom_range(9) == 0) cut = $urandom_range(1, len - 1);
         for (int k = 0; k < cut; k++)
            push_byte(seq[k], (k + 1 == cut) && (cut < len || $urandom_range(5) == 0));
         added += cut;
      end
   endtask

   // wait until every byte is taken and every unit has come back
   task automatic wait_drained();
      @(negedge clock);
      while (bytes_to_send.size() != 0 || req_tvalid || units_due.size() != 0)
         @(negedge clock);
   endtask

   // byte driver
   always @(negedge clock) begin
      byte_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = bytes_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.in_byte;
            req_tlast  <= it.string_end;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long output hold-off
   always @(negedge clock) begin
      if (reset) stall_left <= 0;
      else if (stall_kick) stall_left <= LONG_STALL;
      else if (stall_left != 0) stall_left <= stall_left - 1;
   end

   // output ready
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (stall_left == 0) && ($urandom_range(99) >= take_idle_pct);
   end

   // predict on each accepted byte, check each delivered unit
   always @(posedge clock) begin
      code_unit_entry_type want;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bytes_taken++;
            if (req_tlast) strings_ended++;
            transcode_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            units_seen++;
            if (units_due.size() == 0) begin
               note_mismatch("unit with none due", '0);
            end else begin
               want = units_due.pop_front();
               if (want.code_unit !== rsp_tdata || want.run_last !== rsp_tuser ||
                   want.string_done !== rsp_tlast)
                  note_mismatch("wrong unit", want);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d units still due", units_due.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // sequence of phases
   initial begin
      send_idle_pct = 16;
      take_idle_pct = 61;
      add_directed();
      add_random_bytes(30);
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      wait_drained();

      send_idle_pct = 61;
      take_idle_pct = 16;
      add_random_bytes(35);
      wait_drained();

      // no idling, with one long output hold-off to back up the input
      send_idle_pct = 0;
      take_idle_pct = 0;
      add_random_bytes(40);
      stall_kick <= 1'b1;
      @(negedge clock);
      stall_kick <= 1'b0;
      wait_drained();

      repeat (20) @(negedge clock);
      if (units_due.size() != 0) mismatches += units_due.size();
      $display("covered %0d bytes in %0d ended strings, %0d code units, %0d surrogate pairs",
               bytes_taken, strings_ended, units_seen, surrogate_pairs);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/u8to16_pkg.sv
hw/rtl/u8to16_front.sv
hw/rtl/u8to16_queue.sv
hw/rtl/u8to16_back.sv
hw/rtl/utf8_to_utf16_decoder_unit.sv
bench/utf8_to_utf16_decoder_unit_test.sv
